// File: sv/char_stream_tokenizer_defines.svh
// assertion macros for the character stream tokenizer
`ifndef CHAR_STREAM_TOKENIZER_DEFINES_SVH
`define CHAR_STREAM_TOKENIZER_DEFINES_SVH

`ifndef SYNTHESIS

// condition holds at every clock edge out of reset
`define CST_ASSERT_HOLDS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("tokenizer check failed");

// consequent holds in the same cycle as the antecedent
`define CST_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tokenizer check failed");

// consequent holds in the cycle after the antecedent
`define CST_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tokenizer check failed");

`else

`define CST_ASSERT_HOLDS(label, cond)
`define CST_ASSERT_IMPLIES(label, ante, cons)
`define CST_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// File: sv/cst_pkg.sv
// shared types, constants and helpers for the character stream tokenizer
package cst_pkg;

    // longest lexeme the length field counts before saturating
    localparam int MAX_LEXEME = 255;
    localparam int LEN_CAP_INT = (MAX_LEXEME > 255) ? 255 : MAX_LEXEME;
    localparam logic [7:0] LEN_CAP = 8'(LEN_CAP_INT);

    // result queue geometry
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    // token kinds beyond the punctuators
    localparam logic [4:0] KIND_MINUS   = 5'd14;
    localparam logic [4:0] KIND_ARROW   = 5'd15;
    localparam logic [4:0] KIND_IDENT   = 5'd16;
    localparam logic [4:0] KIND_NUMBER  = 5'd17;
    localparam logic [4:0] KIND_END     = 5'd18;
    localparam logic [4:0] KIND_INVALID = 5'd19;

    // characters with special handling
    localparam logic [7:0] CHAR_DASH       = 8'h2D;
    localparam logic [7:0] CHAR_GT         = 8'h3E;
    localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;

    // punctuator characters, kind is the position in this list
    localparam int PUNCT_COUNT = 14;
    localparam logic [7:0] PUNCT_CHARS [PUNCT_COUNT] = '{
        8'h28, 8'h29, 8'h3C, 8'h3E, 8'h5B, 8'h5D, 8'h2A,
        8'h2E, 8'h3D, 8'h2C, 8'h5F, 8'h40, 8'h23, 8'h2B
    };

    // scanner mode
    typedef enum logic [3:0] {
        MODE_IDLE   = 4'b0001,
        MODE_MINUS  = 4'b0010,
        MODE_IDENT  = 4'b0100,
        MODE_NUMBER = 4'b1000
    } mode_t;

    // input item
    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_text;
    } char_item_t;

    // result item
    typedef struct packed {
        logic [4:0] token_kind;
        logic [7:0] lexeme_length;
        logic       length_saturated;
        logic       last_of_run;
    } token_item_t;

    // scanner state
    typedef struct packed {
        mode_t      mode;
        logic [7:0] run_length;
        logic       run_overflowed;
    } cst_state_t;

    // results of one item
    typedef struct packed {
        logic [1:0]  count;
        token_item_t res0;
        token_item_t res1;
    } step_res_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

endpackage

// File: sv/cst_step.sv
// combinational scanner step: next state and up to two tokens for one item
module cst_step (
    input  cst_pkg::cst_state_t  state,
    input  cst_pkg::char_item_t  item,
    output cst_pkg::cst_state_t  state_next,
    output cst_pkg::step_res_t   res
);
    import cst_pkg::*;

    typedef struct packed {
        logic       emit;
        logic [4:0] kind;
        mode_t      mode;
    } start_t;

    // handle a character with no token pending
    function automatic start_t start_char(input logic [7:0] c);
        start_t     s;
        logic       hit;
        logic [4:0] pk;
        s.emit = 1'b0;
        s.kind = KIND_INVALID;
        s.mode = MODE_IDLE;
        hit = 1'b0;
        pk = '0;
        for (int i = 0; i < PUNCT_COUNT; i++) begin
            if (c == PUNCT_CHARS[i]) begin
                hit = 1'b1;
                pk = 5'(i);
            end
        end
        priority if (is_space(c))
        begin
            s.emit = 1'b0;
        end
        else if (hit)
        begin
            s.emit = 1'b1;
            s.kind = pk;
        end
        else if (c == CHAR_DASH)
        begin
            s.mode = MODE_MINUS;
        end
        else if (is_alpha(c))
        begin
            s.mode = MODE_IDENT;
        end
        else if (is_digit(c))
        begin
            s.mode = MODE_NUMBER;
        end
        else
        begin
            s.emit = 1'b1;
        end
        return s;
    endfunction

    start_t      st;
    logic        use_start;
    logic        pre_v;
    logic        post_v;
    token_item_t pre_tok;
    token_item_t post_tok;
    logic [7:0]  c;
    logic        ident_cont;

    assign c = item.char_code;
    assign st = start_char(c);
    assign ident_cont = is_alpha(c) || is_digit(c) || (c == CHAR_UNDERSCORE);

    // token flushed by the pending state, then token of the new character
    always_comb
    begin
        state_next = state;
        use_start = 1'b0;
        pre_v = 1'b0;
        pre_tok = '{token_kind: KIND_MINUS, lexeme_length: 8'd1,
                    length_saturated: 1'b0, last_of_run: 1'b0};
        post_v = 1'b0;
        post_tok = '{token_kind: st.kind, lexeme_length: 8'd1,
                     length_saturated: 1'b0, last_of_run: 1'b1};
        if (item.end_of_text)
        begin
            unique case (state.mode)
                MODE_MINUS:
                begin
                    pre_v = 1'b1;
                end
                MODE_IDENT:
                begin
                    pre_v = 1'b1;
                    pre_tok.token_kind = KIND_IDENT;
                    pre_tok.lexeme_length = state.run_length;
                    pre_tok.length_saturated = state.run_overflowed;
                end
                MODE_NUMBER:
                begin
                    pre_v = 1'b1;
                    pre_tok.token_kind = KIND_NUMBER;
                    pre_tok.lexeme_length = state.run_length;
                    pre_tok.length_saturated = state.run_overflowed;
                end
                default:
                begin
                    pre_v = 1'b0;
                end
            endcase
            post_v = 1'b1;
            post_tok.token_kind = KIND_END;
            post_tok.lexeme_length = 8'd0;
            state_next.mode = MODE_IDLE;
            state_next.run_length = 8'd0;
            state_next.run_overflowed = 1'b0;
        end
        else
        begin
            unique case (state.mode)
                MODE_MINUS:
                begin
                    pre_v = 1'b1;
                    if (c == CHAR_GT)
                    begin
                        pre_tok.token_kind = KIND_ARROW;
                        pre_tok.lexeme_length = 8'd2;
                        state_next.mode = MODE_IDLE;
                    end
                    else
                    begin
                        use_start = 1'b1;
                    end
                end
                MODE_IDENT, MODE_NUMBER:
                begin
                    if ((state.mode == MODE_IDENT) ? ident_cont : is_digit(c))
                    begin
                        // extend the run, saturating at the cap
                        if (state.run_length < LEN_CAP)
                        begin
                            state_next.run_length = state.run_length + 8'd1;
                        end
                        else
                        begin
                            state_next.run_overflowed = 1'b1;
                        end
                    end
                    else
                    begin
                        pre_v = 1'b1;
                        pre_tok.token_kind = (state.mode == MODE_IDENT) ?
                                             KIND_IDENT : KIND_NUMBER;
                        pre_tok.lexeme_length = state.run_length;
                        pre_tok.length_saturated = state.run_overflowed;
                        use_start = 1'b1;
                    end
                end
                default:
                begin
                    use_start = 1'b1;
                end
            endcase
            if (use_start)
            begin
                post_v = st.emit;
                state_next.mode = st.mode;
                state_next.run_length =
                    ((st.mode == MODE_IDENT) || (st.mode == MODE_NUMBER)) ? 8'd1 : 8'd0;
                state_next.run_overflowed = 1'b0;
            end
        end
    end

    // pack results in emission order, last flag on the final one
    always_comb
    begin
        res.count = {1'b0, pre_v} + {1'b0, post_v};
        res.res0 = pre_v ? pre_tok : post_tok;
        res.res0.last_of_run = !(pre_v && post_v);
        res.res1 = post_tok;
        res.res1.last_of_run = 1'b1;
    end

endmodule

// File: sv/char_stream_tokenizer.sv
// character stream tokenizer top level: input register, scanner, result queue
// path: a character is held in the input register, then its tokens go into the result queue that feeds the output
// throughput: one character per cycle while the four-entry result queue holds at most
//   two tokens; past that the held character waits, so two-token items under a
//   steady drain settle at one token per cycle
// reset: asynchronous, clears scanner mode, run length, input register and queue
`include "char_stream_tokenizer_defines.svh"

module char_stream_tokenizer (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  char_valid,
    output logic                  char_stall,
    input  cst_pkg::char_item_t   char_item,
    output logic                  token_valid,
    input  logic                  token_stall,
    output cst_pkg::token_item_t  token_item
);
    import cst_pkg::*;

    logic               hold_valid_reg;
    logic               hold_valid_next;
    char_item_t         hold_item_reg;
    cst_state_t         state_reg;
    cst_state_t         state_next;
    step_res_t          step_res;
    token_item_t        q_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_next;
    logic [QCNT_W-1:0]  cnt_reg;
    logic [QCNT_W-1:0]  cnt_next;
    logic               advance;
    logic               char_xfer;
    logic               token_xfer;
    logic [QCNT_W-1:0]  push_n;
    logic               pair_adv;
    logic               end_adv;

    // scanner step on the registered character
    cst_step u_step (
        .state      (state_reg),
        .item       (hold_item_reg),
        .state_next (state_next),
        .res        (step_res)
    );

    // handshakes: the held item moves on when the queue has room for two tokens
    assign advance = hold_valid_reg && (cnt_reg <= QCNT_W'(QUEUE_DEPTH - 2));
    assign char_stall = hold_valid_reg && !advance;
    assign char_xfer = char_valid && !char_stall;
    assign token_valid = (cnt_reg != '0);
    assign token_xfer = token_valid && !token_stall;
    assign token_item = q_reg[rd_ptr_reg];
    assign push_n = advance ? QCNT_W'(step_res.count) : '0;

    // pointer and count update
    always_comb
    begin
        hold_valid_next = char_xfer ? 1'b1 : (advance ? 1'b0 : hold_valid_reg);
        wr_ptr_next = wr_ptr_reg + QPTR_W'(push_n);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(token_xfer);
        cnt_next = cnt_reg + push_n - QCNT_W'(token_xfer);
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            state_reg <= '{mode: MODE_IDLE, run_length: 8'd0, run_overflowed: 1'b0};
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg <= cnt_next;
        end
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (char_xfer)
        begin
            hold_item_reg <= char_item;
        end
    end

    // result queue storage, up to two writes per cycle
    always_ff @(posedge clk)
    begin
        if (advance && (step_res.count != 2'd0))
        begin
            q_reg[wr_ptr_reg] <= step_res.res0;
        end
        if (advance && (step_res.count == 2'd2))
        begin
            q_reg[wr_ptr_reg + QPTR_W'(1)] <= step_res.res1;
        end
    end

    // checks
    assign pair_adv = advance && (step_res.count == 2'd2);
    assign end_adv = advance && hold_item_reg.end_of_text;

    `CST_ASSERT_HOLDS(a_queue_bound, cnt_reg <= QCNT_W'(QUEUE_DEPTH))
    `CST_ASSERT_IMPLIES(a_pair_last, pair_adv, !step_res.res0.last_of_run && step_res.res1.last_of_run)
    `CST_ASSERT_NEXT(a_end_idle, end_adv, (state_reg.mode == MODE_IDLE) && (state_reg.run_length == 8'd0))
    `CST_ASSERT_NEXT(a_end_token, end_adv, cnt_reg != '0)

endmodule
